[hdl/sinusoid_grid_pattern_generator_defines.svh]
// assertion macros for the sinusoid grid pattern generator
// used by modules with concurrent checks; expects clk and rst_n in scope
`ifndef SINUSOID_GRID_PATTERN_GENERATOR_DEFINES_SVH
`define SINUSOID_GRID_PATTERN_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SGPG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SGPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sgpg_pkg.sv]
// shared types and constants of the sinusoid grid pattern generator
// no dependencies; imported by all modules of the block
package sgpg_pkg;

  // grid geometry, power of two
  localparam int GRID_SIZE = 64;
  localparam int GRID_LOG2 = $clog2(GRID_SIZE);

  // field widths
  localparam int ROW_W      = 6;
  localparam int FREQ_W     = 24;
  localparam int AMP_W      = 15;
  localparam int PHASE_W    = 16;
  localparam int VALUE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_X       = 2'd0,
    CFG_FREQ_Y       = 2'd1,
    CFG_AMPLITUDE    = 2'd2,
    CFG_PHASE_OFFSET = 2'd3
  } cfg_reg_t;

  // angle quadrant
  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  // signed grid offset 2*idx - N and its products with the frequencies
  localparam int DIFF_W = ((ROW_W > GRID_LOG2) ? ROW_W : GRID_LOG2) + 2;
  localparam int PROD_W = FREQ_W + DIFF_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int ANGLE_LSB = GRID_LOG2 + 1;

  // quarter-wave cosine datapath
  localparam int T_W  = PHASE_W - 1;
  localparam int R_W  = PHASE_W - 2;
  localparam int X_W  = 31;
  localparam int V_W  = 32;
  localparam int P_W  = 31;
  localparam int C_W  = 17;
  localparam int MAG_W = 15;
  localparam int TWO_PI_W = 33;
  localparam int DIV_W = 8;
  localparam int QD_W  = V_W + DIV_W;

  localparam logic [T_W-1:0]      QUARTER_TURN = 15'd16384;
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q30   = 33'd6746518852;
  localparam logic [P_W-1:0]      ONE_Q30      = 31'h4000_0000;

  // taylor-series divisors and their truncated reciprocals, scale 2^32
  localparam int ITERS = 6;
  localparam logic [DIV_W-1:0] DIVS [ITERS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [V_W-1:0] RECIP [ITERS] = '{
    32'((64'd1 << 32) / 64'd132),
    32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd2)
  };

  // classified request held in the queue
  typedef struct packed {
    logic           neg;
    logic [T_W-1:0] t;
  } sgpg_item_t;

  // queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } sgpg_q_stat_t;

  // per-stage control of the back pipeline
  typedef struct packed {
    logic valid;
    logic neg;
  } sgpg_ctl_t;

endpackage

[hdl/sgpg_front.sv]
// front end: accepts grid positions, forms the wrapped angle and its quadrant
// depends on sgpg_pkg; feeds sgpg_queue
module sgpg_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sgpg_pkg::ROW_W-1:0]          in_row,
  input  logic [sgpg_pkg::ROW_W-1:0]          in_col,
  input  logic signed [sgpg_pkg::FREQ_W-1:0]  freq_x_i,
  input  logic signed [sgpg_pkg::FREQ_W-1:0]  freq_y_i,
  input  logic [sgpg_pkg::PHASE_W-1:0]        phase_offset_i,
  input  sgpg_pkg::sgpg_q_stat_t              q_stat,
  output logic                                push,
  output sgpg_pkg::sgpg_item_t                push_item
);
  import sgpg_pkg::*;

  logic                     f1_valid_r;
  logic                     f1_valid_nxt;
  logic                     front_en;
  logic signed [DIFF_W-1:0] d_row;
  logic signed [DIFF_W-1:0] d_col;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic signed [NUM_W-1:0]  num;
  logic [PHASE_W-1:0]       angle;
  logic [R_W-1:0]           rem;

  assign in_stall = f1_valid_r && q_stat.full;
  assign front_en = !in_stall;
  assign push     = f1_valid_r && !q_stat.full;

  // 2*idx - N
  assign d_row = $signed(DIFF_W'({in_row, 1'b0})) - $signed(DIFF_W'(GRID_SIZE));
  assign d_col = $signed(DIFF_W'({in_col, 1'b0})) - $signed(DIFF_W'(GRID_SIZE));

  assign f1_valid_nxt = front_en ? in_valid : f1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && front_en) begin
      prod_x_r <= PROD_W'(freq_x_i) * PROD_W'(d_col);
      prod_y_r <= PROD_W'(freq_y_i) * PROD_W'(d_row);
    end
  end

  // floor((num + N) / 2N) mod one turn is a bit slice of num + N
  always_comb begin
    num   = NUM_W'(prod_y_r) + NUM_W'(prod_x_r) + NUM_W'(GRID_SIZE);
    angle = num[ANGLE_LSB +: PHASE_W] + phase_offset_i;
    rem   = angle[R_W-1:0];
    unique case (quad_t'(angle[PHASE_W-1 -: 2]))
      QUAD_I: begin
        push_item.t   = {1'b0, rem};
        push_item.neg = 1'b0;
      end
      QUAD_II: begin
        push_item.t   = QUARTER_TURN - {1'b0, rem};
        push_item.neg = 1'b1;
      end
      QUAD_III: begin
        push_item.t   = {1'b0, rem};
        push_item.neg = 1'b1;
      end
      QUAD_IV: begin
        push_item.t   = QUARTER_TURN - {1'b0, rem};
        push_item.neg = 1'b0;
      end
    endcase
  end

endmodule

[hdl/sgpg_queue.sv]
// short request queue between front end and cosine pipeline
// depends on sgpg_pkg and the assertion macro header
`include "sinusoid_grid_pattern_generator_defines.svh"

module sgpg_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sgpg_pkg::sgpg_item_t   push_item,
  input  logic                   pop,
  output sgpg_pkg::sgpg_item_t   head_item,
  output sgpg_pkg::sgpg_q_stat_t q_stat
);
  import sgpg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sgpg_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_item    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `SGPG_ASSERT_IMPL(a_no_push_full, push, !q_stat.full, "push into full queue")
  `SGPG_ASSERT_IMPL(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
  `SGPG_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + CNT_W'(1), "count lost a push")
  `SGPG_ASSERT_NEXT(a_count_down, pop && !push, count_r == $past(count_r) - CNT_W'(1), "count lost a pop")

endmodule

[hdl/sgpg_back.sv]
// back end: pipelined quarter-wave cosine, amplitude scaling and output register
// depends on sgpg_pkg; pulls classified requests from sgpg_queue
module sgpg_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sgpg_pkg::AMP_W-1:0]          amplitude_i,
  input  sgpg_pkg::sgpg_item_t                head_item,
  input  sgpg_pkg::sgpg_q_stat_t              q_stat,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sgpg_pkg::VALUE_W-1:0] out_pattern_value
);
  import sgpg_pkg::*;

  // x, x2, three stages per series term, magnitude
  localparam int NSTG   = 3 + 3 * ITERS;
  localparam int X2_LEN = 3 * ITERS - 2;

  logic                      back_en;
  sgpg_ctl_t                 ctl_r [NSTG];
  sgpg_ctl_t                 ctl_nxt;
  logic [X_W-1:0]            x_r;
  logic [V_W-1:0]            x2_r [X2_LEN];
  logic [V_W-1:0]            va_r [ITERS];
  logic [V_W-1:0]            vb_r [ITERS];
  logic [V_W-1:0]            q_r  [ITERS];
  logic [P_W-1:0]            p_r  [ITERS];
  logic [MAG_W-1:0]          mag_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;
  logic [47:0]               prod_t;
  logic [61:0]               prod_x2;
  logic [C_W-1:0]            cos_q16;
  logic [31:0]               prod_mag;

  assign back_en = !out_valid_r || !out_stall;
  assign pop     = back_en && !q_stat.empty;

  assign ctl_nxt.valid = pop;
  assign ctl_nxt.neg   = head_item.neg;

  assign prod_t  = 48'(head_item.t) * 48'(TWO_PI_Q30);
  assign prod_x2 = 62'(x_r) * 62'(x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        ctl_r[s] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      ctl_r[0] <= ctl_nxt;
      for (int s = 1; s < NSTG; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
      out_valid_r <= ctl_r[NSTG-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      x_r     <= prod_t[16 +: X_W];
      x2_r[0] <= prod_x2[30 +: V_W];
      for (int j = 1; j < X2_LEN; j++) begin
        x2_r[j] <= x2_r[j-1];
      end
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_term
    logic [P_W-1:0]  p_in;
    logic [62:0]     prod_a;
    logic [63:0]     prod_b;
    logic [QD_W-1:0] qd;
    logic [QD_W-1:0] rem;
    logic [V_W-1:0]  s_div;
    logic [P_W-1:0]  p_nxt;

    if (i == 0) begin : g_first
      assign p_in = ONE_Q30;
    end else begin : g_chain
      assign p_in = p_r[i-1];
    end

    // (x2 * p) >> 30, then divide by the term divisor via reciprocal
    assign prod_a = 63'(x2_r[3*i]) * 63'(p_in);
    assign prod_b = 64'(va_r[i]) * 64'(RECIP[i]);

    // quotient estimate is low by at most one
    always_comb begin
      qd    = QD_W'(q_r[i]) * QD_W'(DIVS[i]);
      rem   = QD_W'(vb_r[i]) - qd;
      s_div = q_r[i] + V_W'(rem >= QD_W'(DIVS[i]));
      p_nxt = (s_div >= V_W'(ONE_Q30)) ? '0 : P_W'(V_W'(ONE_Q30) - s_div);
    end

    always_ff @(posedge clk) begin
      if (back_en) begin
        va_r[i] <= prod_a[30 +: V_W];
        q_r[i]  <= prod_b[32 +: V_W];
        vb_r[i] <= va_r[i];
        p_r[i]  <= p_nxt;
      end
    end
  end

  // q30 to q16 with rounding, then amplitude with half-up rounding
  assign cos_q16  = C_W'((32'(p_r[ITERS-1]) + 32'd8192) >> 14);
  assign prod_mag = 32'(amplitude_i) * 32'(cos_q16) + 32'd32768;

  assign value_nxt = ctl_r[NSTG-1].neg ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

  always_ff @(posedge clk) begin
    if (back_en) begin
      mag_r   <= prod_mag[16 +: MAG_W];
      value_r <= value_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pattern_value = value_r;

endmodule

[hdl/sinusoid_grid_pattern_generator.sv]
// top level of the sinusoid grid pattern generator: config registers and wiring
// depends on sgpg_pkg, sgpg_front, sgpg_queue and sgpg_back
//
//   channel | signals                          | direction | meaning
//   --------+----------------------------------+-----------+-------------------------------
//   in      | in_valid, in_stall, row, col     | into      | one grid position per request
//   out     | out_valid, out_stall, value      | out of    | one pattern value per request
//   cfg     | cfg_we, cfg_index, cfg_wdata     | into      | register writes, no read-back
//
// one request per cycle sustained while out_stall is low; the cosine pipeline computes six
// series terms, three stages each, and sits behind the front register and queue
// rst_n is synchronous; it clears valid bits, queue pointers and config registers
// out_stall freezes the whole back pipeline; the queue then fills and in_stall
// rises only when it is full and the front register holds a request
module sinusoid_grid_pattern_generator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sgpg_pkg::ROW_W-1:0]          in_row,
  input  logic [sgpg_pkg::ROW_W-1:0]          in_col,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sgpg_pkg::VALUE_W-1:0] out_pattern_value,
  input  logic                                cfg_we,
  input  logic [sgpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgpg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sgpg_pkg::*;

  // configuration registers; the user must write them only while idle, the block does not enforce this
  logic signed [FREQ_W-1:0] freq_x_r;
  logic signed [FREQ_W-1:0] freq_y_r;
  logic [AMP_W-1:0]         amplitude_r;
  logic [PHASE_W-1:0]       phase_offset_r;

  // queue handshake between the two halves
  logic         push;
  logic         pop;
  sgpg_item_t   push_item;
  sgpg_item_t   head_item;
  sgpg_q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_x_r       <= '0;
      freq_y_r       <= '0;
      amplitude_r    <= '0;
      phase_offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FREQ_X:       freq_x_r       <= $signed(cfg_wdata[FREQ_W-1:0]);
        CFG_FREQ_Y:       freq_y_r       <= $signed(cfg_wdata[FREQ_W-1:0]);
        CFG_AMPLITUDE:    amplitude_r    <= cfg_wdata[AMP_W-1:0];
        CFG_PHASE_OFFSET: phase_offset_r <= cfg_wdata[PHASE_W-1:0];
      endcase
    end
  end

  // front: frequency products, angle wrap, quadrant fold
  sgpg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_row         (in_row),
    .in_col         (in_col),
    .freq_x_i       (freq_x_r),
    .freq_y_i       (freq_y_r),
    .phase_offset_i (phase_offset_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  // decouples front acceptance from back-end stalls
  sgpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // back: quarter-wave cosine series, amplitude scale, sign, output register
  sgpg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .amplitude_i       (amplitude_r),
    .head_item         (head_item),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pattern_value (out_pattern_value)
  );

endmodule
